// File: rtl/core/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg
// Shared widths, codes and interface structs of the code sequence classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  // capacity of the number store
  localparam int MAX_LEN = 1024;

  // widths
  localparam int NUM_W  = 16;
  localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int EXT_W  = CNT_W + 1;
  localparam int AXIS_W = NUM_W + ADDR_W + 1;
  localparam int SUM_W  = 26;
  localparam int LEN_W  = 11;
  localparam int TYPE_W = 3;

  // axis codes
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_ALL = 2'd3;

  // code type codes
  localparam logic [TYPE_W-1:0] TYPE_OSO  = 3'd0;
  localparam logic [TYPE_W-1:0] TYPE_OSNO = 3'd1;
  localparam logic [TYPE_W-1:0] TYPE_ONS  = 3'd2;
  localparam logic [TYPE_W-1:0] TYPE_CS   = 3'd3;
  localparam logic [TYPE_W-1:0] TYPE_CNS  = 3'd4;

  // store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [NUM_W-1:0]  data;
  } store_wr_t;

  // closed check request
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] len;
  } chk_req_t;

  // closed check status
  typedef struct packed {
    logic done;
    logic closed;
  } chk_status_t;

endpackage

`default_nettype wire

// File: rtl/core/csc_closed_check.sv
// ----------------------------------------------------------------------------
// csc_closed_check
// Number store with two read ports and the sequencer of the closed check.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_closed_check
  import csc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire store_wr_t   wr,
  input  wire chk_req_t    req,
  output chk_status_t      status
);

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_PAR  = 4'b0010,
    C_PCHK = 4'b0100,
    C_CMP  = 4'b1000
  } cstate_t;

  cstate_t           state;
  logic [CNT_W-1:0]  len;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  k;
  logic              pend;
  logic              pend_last;

  logic [NUM_W-1:0]  mem [MAX_LEN];
  logic [NUM_W-1:0]  rd_a;
  logic [NUM_W-1:0]  rd_b;

  logic [CNT_W-1:0]  half;
  logic [CNT_W-1:0]  half_m1;
  logic [CNT_W-1:0]  half_m2;
  logic [CNT_W-1:0]  a_addr;
  logic [CNT_W-1:0]  b_addr;
  logic [EXT_W-1:0]  b_ext;
  logic              issue;
  logic              both_even;
  logic              last_i;

  assign half      = len >> 1;
  assign half_m1   = half - CNT_W'(1);
  assign half_m2   = half - CNT_W'(2);
  assign issue     = (k != half_m1);
  assign both_even = !rd_a[0] && !rd_b[0];
  assign last_i    = (idx == half_m1);

  // read addresses: parity pair, or mirrored pair around the candidate
  always_comb begin
    b_ext = EXT_W'(idx) + EXT_W'(len) - EXT_W'(1) - EXT_W'(k);
    if (state == C_PAR) begin
      a_addr = idx;
      b_addr = idx + half;
    end else begin
      a_addr = idx + CNT_W'(1) + k;
      if (b_ext >= EXT_W'(len)) begin
        b_addr = CNT_W'(b_ext - EXT_W'(len));
      end else begin
        b_addr = CNT_W'(b_ext);
      end
    end
  end

  // store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_a <= mem[a_addr[ADDR_W-1:0]];
    rd_b <= mem[b_addr[ADDR_W-1:0]];
  end

  // check sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= C_IDLE;
      pend          <= 1'b0;
      pend_last     <= 1'b0;
      status.done   <= 1'b0;
      status.closed <= 1'b0;
    end else begin
      status.done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (req.start) begin
            len   <= req.len;
            idx   <= '0;
            state <= C_PAR;
          end
        end
        C_PAR: begin
          state <= C_PCHK;
        end
        C_PCHK: begin
          if (both_even && half == CNT_W'(1)) begin
            status.done   <= 1'b1;
            status.closed <= 1'b1;
            state         <= C_IDLE;
          end else if (both_even) begin
            k     <= '0;
            pend  <= 1'b0;
            state <= C_CMP;
          end else if (last_i) begin
            status.done   <= 1'b1;
            status.closed <= 1'b0;
            state         <= C_IDLE;
          end else begin
            idx   <= idx + CNT_W'(1);
            state <= C_PAR;
          end
        end
        C_CMP: begin
          priority if (pend && rd_a != rd_b) begin
            // mismatch: move on to the next candidate, or finish as not closed after the last one
            pend <= 1'b0;
            if (last_i) begin
              status.done   <= 1'b1;
              status.closed <= 1'b0;
              state         <= C_IDLE;
            end else begin
              idx   <= idx + CNT_W'(1);
              state <= C_PAR;
            end
          end else if (pend && pend_last) begin
            pend          <= 1'b0;
            status.done   <= 1'b1;
            status.closed <= 1'b1;
            state         <= C_IDLE;
          end else begin
            pend      <= issue;
            pend_last <= (k == half_m2);
            if (issue) begin
              k <= k + CNT_W'(1);
            end
          end
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
    end
  end

  // an outstanding compare only exists while comparing
  a_pend_in_cmp: assert property (@(posedge clk) disable iff (rst)
    pend |-> state == C_CMP)
    else $error("compare pending outside compare state");

  // completion is a single-cycle pulse back in idle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    status.done |-> state == C_IDLE && !$past(status.done))
    else $error("check completion not a clean pulse");

  // mirror compares stay inside the stored sequence
  a_cmp_addr: assert property (@(posedge clk) disable iff (rst)
    state == C_CMP |-> a_addr < len && b_addr < len)
    else $error("compare address beyond sequence length");

endmodule

`default_nettype wire

// File: rtl/core/code_sequence_classifier.sv
// ----------------------------------------------------------------------------
// code_sequence_classifier
// Loads a code sequence and classifies it as odd/even, closed and stable.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one code number per request;
//   the request with last = 1 ends the sequence. Output channel
//   (out_valid/out_ready) delivers one classification per sequence.
//   Numbers load at one per cycle while in_ready is high. Parity, axis
//   sums and the total are tracked on the fly, so odd-length and
//   too-long sequences go straight to the finish state and then to the
//   output register. An even length L (h = L/2) runs the closed check
//   over the number store, two reads per cycle: each candidate first
//   reads and checks its parity pair (i and i + h), then runs pipelined
//   mirror compares through the two registered read ports of the store.
//   No new number is taken while the check runs. The result sits in an
//   output register, so the next sequence can load while it waits; after
//   a further last request the input stalls until the register is free.
//   Reset clears all sequence state; the store needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module code_sequence_classifier
  import csc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [NUM_W-1:0]  code_number,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [TYPE_W-1:0]      code_type,
  output logic                   is_odd,
  output logic                   is_closed,
  output logic                   is_stable,
  output logic [SUM_W-1:0]       code_sum,
  output logic [LEN_W-1:0]       seq_length,
  output logic                   too_long
);

  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_CHECK = 3'b010,
    S_FIN   = 3'b100
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic signed [AXIS_W-1:0]  axis_sums [3];
  logic [1:0]                axis_older;
  logic [1:0]                axis_newer;
  logic [SUM_W-1:0]          running_sum;
  logic                      overflow_seen;
  logic                      prev_odd;
  logic                      closed;
  logic                      chk_start;

  logic                      accept;
  logic                      stored;
  logic [CNT_W-1:0]          count_next;
  logic [1:0]                axis_sel;
  logic signed [AXIS_W-1:0]  num_ext;
  logic                      odd;
  logic                      stable;
  logic [TYPE_W-1:0]         type_sel;
  logic                      out_free;

  store_wr_t                 wr;
  chk_req_t                  chk_req;
  chk_status_t               chk_status;

  assign in_ready   = (state == S_LOAD);
  assign accept     = in_valid && in_ready;
  assign stored     = (count < CNT_W'(MAX_LEN));
  assign count_next = stored ? count + CNT_W'(1) : count;
  assign num_ext    = $signed(AXIS_W'(code_number));
  assign out_free   = !out_valid || out_ready;

  // axis of the incoming position
  always_comb begin
    priority if (count == '0) begin
      axis_sel = AXIS_X;
    end else if (count == CNT_W'(1)) begin
      axis_sel = AXIS_Y;
    end else if (prev_odd) begin
      axis_sel = 2'(AXIS_ALL - axis_older - axis_newer);
    end else begin
      axis_sel = axis_older;
    end
  end

  // store write and check request
  assign wr.en       = accept && stored;
  assign wr.addr     = count[ADDR_W-1:0];
  assign wr.data     = code_number;
  assign chk_req.start = chk_start;
  assign chk_req.len   = count;

  csc_closed_check u_check (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .req    (chk_req),
    .status (chk_status)
  );

  // classification from the gathered state
  always_comb begin
    odd    = count[0];
    stable = odd || (axis_sums[0] == '0 && axis_sums[1] == '0 && axis_sums[2] == '0);
    priority if (closed) begin
      type_sel = stable ? TYPE_CS : TYPE_CNS;
    end else if (!stable) begin
      type_sel = TYPE_ONS;
    end else begin
      type_sel = odd ? TYPE_OSO : TYPE_OSNO;
    end
  end

  // sequence state and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      count         <= '0;
      axis_sums[0]  <= '0;
      axis_sums[1]  <= '0;
      axis_sums[2]  <= '0;
      axis_older    <= AXIS_X;
      axis_newer    <= AXIS_Y;
      running_sum   <= '0;
      overflow_seen <= 1'b0;
      prev_odd      <= 1'b0;
      closed        <= 1'b0;
      chk_start     <= 1'b0;
    end else begin
      chk_start <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (stored) begin
              for (int j = 0; j < 3; j++) begin
                if (axis_sel == 2'(j)) begin
                  axis_sums[j] <= count[0] ? axis_sums[j] - num_ext
                                           : axis_sums[j] + num_ext;
                end
              end
              if (count > CNT_W'(1)) begin
                axis_older <= axis_newer;
                axis_newer <= axis_sel;
              end
              prev_odd    <= code_number[0];
              running_sum <= running_sum + SUM_W'(code_number);
              count       <= count_next;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last) begin
              closed <= 1'b0;
              if (!stored || overflow_seen || count_next[0]) begin
                state <= S_FIN;
              end else begin
                chk_start <= 1'b1;
                state     <= S_CHECK;
              end
            end
          end
        end
        S_CHECK: begin
          if (chk_status.done) begin
            closed <= chk_status.closed;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            count         <= '0;
            axis_sums[0]  <= '0;
            axis_sums[1]  <= '0;
            axis_sums[2]  <= '0;
            axis_older    <= AXIS_X;
            axis_newer    <= AXIS_Y;
            running_sum   <= '0;
            overflow_seen <= 1'b0;
            state         <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      if (overflow_seen) begin
        code_type  <= '0;
        is_odd     <= 1'b0;
        is_closed  <= 1'b0;
        is_stable  <= 1'b0;
        code_sum   <= '0;
        seq_length <= '0;
        too_long   <= 1'b1;
      end else begin
        code_type  <= type_sel;
        is_odd     <= odd;
        is_closed  <= closed;
        is_stable  <= stable;
        code_sum   <= running_sum;
        seq_length <= LEN_W'(count);
        too_long   <= 1'b0;
      end
    end
  end

  // a check is only started on entry to the check state
  a_start_in_check: assert property (@(posedge clk) disable iff (rst)
    chk_start |-> state == S_CHECK)
    else $error("closed check started outside check state");

  // the fill count never passes the store capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_LEN))
    else $error("fill count beyond capacity");

  // check completion only arrives while waiting for it
  a_done_in_check: assert property (@(posedge clk) disable iff (rst)
    chk_status.done |-> state == S_CHECK)
    else $error("unexpected closed check completion");

  // an overflow result carries no other information
  a_too_long_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> code_sum == '0 && seq_length == '0 && code_type == '0)
    else $error("overflow result with nonzero fields");

endmodule

`default_nettype wire
